/* rtl/length_prefixed_frame_deframer_macros.svh */
// Assertion macros used by the checker of the deframer.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPFD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");

// The consequent must hold in the cycle after the antecedent.
`define LPFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

/* rtl/lpfd_pkg.sv */
package lpfd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 16;

  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 16'd4096;

  typedef enum logic {
    OP_BYTE          = 1'b0,
    OP_SESSION_RESET = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_BADLEN = 2'd1,
    KIND_ABORT  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_LEN_LO  = 2'd0,
    PH_LEN_HI  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_ERROR   = 2'd3
  } phase_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] payload_byte;
    logic              last_of_frame;
    logic [LEN_W-1:0]  frame_length;
  } out_item_t;

endpackage

/* rtl/length_prefixed_frame_deframer.sv */
// Deframes a byte stream of frames, each a 2-byte little-endian length followed by
// that many payload bytes. Every payload byte leaves as one result transaction, the
// final one of a frame with last_of_frame set. A length of zero or above max_payload
// is reported once as an invalid-length result, after which all bytes are dropped
// until a session reset; a session reset during a payload reports an abort so the
// consumer can discard the partial frame. One item is accepted per clock while the
// output is not stalled: each item passes an input register and a result register,
// the phase and byte counter updating as it moves between them. max_payload is
// written through the cfg port, which is always ready; the user must do so only
// while the block is idle, as the block itself does not enforce this.
module length_prefixed_frame_deframer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  lpfd_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output lpfd_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lpfd_pkg::LEN_W-1:0] cfg_data
);
  import lpfd_pkg::*;

  logic [LEN_W-1:0]  max_payload_r;
  logic              s1_valid_r;
  in_item_t          s1_item_r;
  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] length_low_r, length_low_nxt;
  logic [LEN_W-1:0]  frame_len_r, frame_len_nxt;
  logic [LEN_W-1:0]  bytes_left_r, bytes_left_nxt;
  logic              out_valid_r;
  out_item_t         out_data_r;
  logic              out_free;
  logic              s1_adv;
  logic              res_valid;
  out_item_t         res;
  logic [LEN_W-1:0]  rx_len;
  logic              len_bad;
  logic              is_last;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign rx_len  = {s1_item_r.data_byte, length_low_r};
  assign len_bad = (rx_len == '0) || (rx_len > max_payload_r);
  assign is_last = (bytes_left_r <= LEN_W'(1));

  always_comb begin
    phase_nxt      = phase_r;
    length_low_nxt = length_low_r;
    frame_len_nxt  = frame_len_r;
    bytes_left_nxt = bytes_left_r;
    if (s1_item_r.op == OP_SESSION_RESET) begin
      phase_nxt      = PH_LEN_LO;
      length_low_nxt = '0;
      frame_len_nxt  = '0;
      bytes_left_nxt = '0;
    end else begin
      case (phase_r)
        PH_LEN_LO: begin
          length_low_nxt = s1_item_r.data_byte;
          phase_nxt      = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          if (len_bad) begin
            phase_nxt = PH_ERROR;
          end else begin
            frame_len_nxt  = rx_len;
            bytes_left_nxt = rx_len;
            phase_nxt      = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (is_last) begin
            bytes_left_nxt = '0;
            phase_nxt      = PH_LEN_LO;
          end else begin
            bytes_left_nxt = bytes_left_r - LEN_W'(1);
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    if (s1_item_r.op == OP_SESSION_RESET) begin
      if (phase_r == PH_PAYLOAD) begin
        res_valid        = 1'b1;
        res.kind         = KIND_ABORT;
        res.frame_length = frame_len_r;
      end
    end else begin
      case (phase_r)
        PH_LEN_HI: begin
          if (len_bad) begin
            res_valid        = 1'b1;
            res.kind         = KIND_BADLEN;
            res.frame_length = rx_len;
          end
        end
        PH_PAYLOAD: begin
          res_valid         = 1'b1;
          res.kind          = KIND_DATA;
          res.payload_byte  = s1_item_r.data_byte;
          res.last_of_frame = is_last;
          res.frame_length  = frame_len_r;
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_payload_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_LEN_LO;
      length_low_r <= '0;
      frame_len_r  <= '0;
      bytes_left_r <= '0;
    end else if (s1_adv) begin
      phase_r      <= phase_nxt;
      length_low_r <= length_low_nxt;
      frame_len_r  <= frame_len_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= res_valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= res;
    end
  end

endmodule

/* rtl/lpfd_checker.sv */
`include "length_prefixed_frame_deframer_macros.svh"

module lpfd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input lpfd_pkg::out_item_t out_data
);
  import lpfd_pkg::*;

  // A stalled result transaction stays offered and unchanged.
  `LPFD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `LPFD_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data))

  // Only payload results carry a byte or a last-of-frame mark.
  `LPFD_ASSERT_SAME(a_nondata_zero, clk, rst_n,
                    out_valid && (out_data.kind != KIND_DATA),
                    (out_data.payload_byte == '0) && !out_data.last_of_frame)

  // Payload and abort results belong to a frame that passed the length check.
  `LPFD_ASSERT_SAME(a_len_nonzero, clk, rst_n,
                    out_valid && (out_data.kind != KIND_BADLEN),
                    out_data.frame_length != '0)

endmodule

bind length_prefixed_frame_deframer lpfd_checker u_lpfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
